// File: hw/rtl/prime_factorizer_unit_defines.svh
// Assertion macros used by the checker file of the factorizer.
`ifndef PRIME_FACTORIZER_UNIT_DEFINES_SVH
`define PRIME_FACTORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PFU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pfu_pkg.sv
`timescale 1ns / 1ps

package pfu_pkg;

    // Data path width and result limit per input
    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int PC_W        = 4;

    localparam logic [DATA_W-1:0] TWO   = DATA_W'(2);
    localparam logic [DATA_W-1:0] THREE = DATA_W'(3);
    localparam logic [DATA_W-1:0] ONE   = DATA_W'(1);

    // Wait condition that holds a step until it can execute
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_DIV,
        WAIT_OUT
    } wait_t;

    // Datapath action of a step, done once the wait condition is met
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV,
        ACT_EMIT_D,
        ACT_STEP_D,
        ACT_EMIT_REM
    } act_t;

    // Jump condition; the step falls through to the next one when false
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_REM_LE1,
        COND_Q_LT_D,
        COND_R_NZ,
        COND_N_FULL
    } cond_t;

    typedef struct packed {
        wait_t           wait_on;
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Step addresses
    localparam logic [PC_W-1:0] STEP_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_CHK_SMALL = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_DIV_GO    = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_DIV_WAIT  = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_REM_TEST  = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_FULL_TEST = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_EMIT_D    = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_NEXT_D    = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_TAIL      = PC_W'(8);
    localparam logic [PC_W-1:0] STEP_EMIT_REM  = PC_W'(9);

    // Control store: trial division program
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{WAIT_NONE, ACT_NONE, COND_ALWAYS, STEP_IDLE};
        unique case (pc)
            STEP_IDLE:      w = '{WAIT_IN,   ACT_LOAD,     COND_NEVER,   STEP_IDLE};
            STEP_CHK_SMALL: w = '{WAIT_NONE, ACT_NONE,     COND_REM_LE1, STEP_EMIT_REM};
            STEP_DIV_GO:    w = '{WAIT_NONE, ACT_DIV,      COND_NEVER,   STEP_IDLE};
            STEP_DIV_WAIT:  w = '{WAIT_DIV,  ACT_NONE,     COND_Q_LT_D,  STEP_TAIL};
            STEP_REM_TEST:  w = '{WAIT_NONE, ACT_NONE,     COND_R_NZ,    STEP_NEXT_D};
            STEP_FULL_TEST: w = '{WAIT_NONE, ACT_NONE,     COND_N_FULL,  STEP_EMIT_REM};
            STEP_EMIT_D:    w = '{WAIT_OUT,  ACT_EMIT_D,   COND_ALWAYS,  STEP_DIV_GO};
            STEP_NEXT_D:    w = '{WAIT_NONE, ACT_STEP_D,   COND_ALWAYS,  STEP_DIV_GO};
            STEP_TAIL:      w = '{WAIT_NONE, ACT_NONE,     COND_REM_LE1, STEP_IDLE};
            STEP_EMIT_REM:  w = '{WAIT_OUT,  ACT_EMIT_REM, COND_ALWAYS,  STEP_IDLE};
            default:        w = '{WAIT_NONE, ACT_NONE,     COND_ALWAYS,  STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/pfu_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module pfu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pfu_pkg::DATA_W-1:0]  dividend,
    input  logic [pfu_pkg::DATA_W-1:0]  divisor,
    output logic                        busy,
    output logic [pfu_pkg::DATA_W-1:0]  quotient,
    output logic [pfu_pkg::DATA_W-1:0]  remainder
);
    import pfu_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    part_reg, part_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;
    logic                 ge;

    // Shift in next dividend bit and trial-subtract
    always_comb begin
        shifted = {part_reg, quo_reg[DATA_W-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = (shifted >= {1'b0, divisor});
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            part_next = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DATA_W-2:0], ge};
            part_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        part_reg <= part_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg;

endmodule

// File: hw/rtl/prime_factorizer_unit.sv
`timescale 1ns / 1ps
// Prime factorizer by trial division.
// Input stream (s_): one transaction carries a number in s_tdata. s_tready is
// high only while the block waits for a new number.
// Output stream (m_): one transaction per prime factor, ascending, with
// repeats; m_tlast marks the final factor of a number. Input 0 gives a single
// factor 0, input 1 a single factor 1, each with m_tlast set.
// Sequencing: a small microprogram in a control store runs the loop; each
// trial divisor takes one pass through a shared bit-serial divider. A number
// needs up to about sqrt(n)/2 divisors. Input 0 or 1 passes the check step
// and the emit step before its factor shows.
// s_tready rises in the cycle the final factor appears when a leftover cofactor
// closes the run, and only after one more division and the tail step when a
// divisor closes it (that division is needed to see the cofactor 1).
// Reset (aresetn low, synchronous) returns the sequencer to its idle step and
// empties the output register; no clearing pass is needed.
// Receiver stall: the output register holds the factor; the sequencer waits
// at its emit step until the register is free, no factor is lost.
module prime_factorizer_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfu_pkg::DATA_W-1:0]  s_tdata,   // [31:0] number
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pfu_pkg::DATA_W-1:0]  m_tdata,   // [31:0] factor
    output logic                        m_tlast
);
    import pfu_pkg::*;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    ucode_t            uc;
    logic              wait_ok;
    logic              cond_true;
    logic              out_room;
    logic              div_start;
    logic              div_busy;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] div_r;

    // Shared divider: rem / d
    pfu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Fetch control word
    assign uc       = ucode_rom(pc_reg);
    assign out_room = !m_tvalid_reg || m_tready;

    // Wait and jump condition decode
    always_comb begin
        unique case (uc.wait_on)
            WAIT_NONE: wait_ok = 1'b1;
            WAIT_IN:   wait_ok = s_tvalid;
            WAIT_DIV:  wait_ok = !div_busy;
            WAIT_OUT:  wait_ok = out_room;
            default:   wait_ok = 1'b0;
        endcase
        unique case (uc.cond)
            COND_NEVER:   cond_true = 1'b0;
            COND_ALWAYS:  cond_true = 1'b1;
            COND_REM_LE1: cond_true = (rem_reg <= ONE);
            COND_Q_LT_D:  cond_true = (div_q < d_reg);
            COND_R_NZ:    cond_true = (div_r != '0);
            COND_N_FULL:  cond_true = (n_reg == CNT_W'(MAX_RESULTS - 1));
            default:      cond_true = 1'b0;
        endcase
    end

    // Step counter
    always_comb begin
        pc_next = pc_reg;
        if (wait_ok) begin
            pc_next = cond_true ? uc.target : pc_reg + PC_W'(1);
        end
    end

    assign s_tready  = (uc.act == ACT_LOAD);
    assign div_start = wait_ok && (uc.act == ACT_DIV);

    // Datapath actions and output register
    always_comb begin
        rem_next      = rem_reg;
        d_next        = d_reg;
        n_next        = n_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (wait_ok) begin
            case (uc.act)
                ACT_LOAD: begin
                    rem_next = s_tdata;
                    d_next   = TWO;
                    n_next   = '0;
                end
                ACT_EMIT_D: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = d_reg;
                    m_tlast_next  = (div_q == ONE);
                    rem_next      = div_q;
                    n_next        = n_reg + CNT_W'(1);
                end
                ACT_STEP_D: begin
                    d_next = (d_reg == TWO) ? THREE : d_reg + TWO;
                end
                ACT_EMIT_REM: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rem_reg;
                    m_tlast_next  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: hw/rtl/pfu_checker.sv
`timescale 1ns / 1ps
`include "prime_factorizer_unit_defines.svh"

// Port-level checks for the factorizer
module pfu_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pfu_pkg::DATA_W-1:0]  m_tdata,
    input logic                        m_tlast
);
    import pfu_pkg::*;

    // Stalled result transaction holds its payload
    `PFU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled factor changed")

    // One number at a time: no second input right after an accepted one
    `PFU_ASSERT_NEXT(a_one_run, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

    // A run that has not shown its final factor takes no new input
    `PFU_ASSERT_NOW(a_run_open, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input ready inside a run")

    // Factors before the final one are at least two
    `PFU_ASSERT_NOW(a_mid_factor, aclk, aresetn, m_tvalid && !m_tlast, m_tdata >= TWO, "inner factor below two")

endmodule

bind prime_factorizer_unit pfu_checker u_pfu_checker (.*);
